>>> src/bqc_pkg.sv
// Shared constants for the biquad cascade filter: defaults, register indexes, coefficient slots.
package bqc_pkg;

    localparam int DEF_MAX_SECTIONS = 4;
    localparam int DEF_DATA_WIDTH   = 24;
    localparam int DEF_COEF_WIDTH   = 24;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTIONS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX  = 2'd2;

    localparam int SECTIONS_W = 3;

    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A0 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd5;
    localparam logic [SLOT_W-1:0] NUM_SLOTS = 3'd6;

    // Product terms of one section, in the order they are accumulated
    localparam int TERM_W = 3;
    localparam logic [TERM_W-1:0] TERM_X0 = 3'd0;
    localparam logic [TERM_W-1:0] TERM_X1 = 3'd1;
    localparam logic [TERM_W-1:0] TERM_X2 = 3'd2;
    localparam logic [TERM_W-1:0] TERM_Y1 = 3'd3;
    localparam logic [TERM_W-1:0] TERM_Y2 = 3'd4;

    function automatic logic [SLOT_W-1:0] term_slot(input logic [TERM_W-1:0] term);
        logic [SLOT_W-1:0] slot;
        unique case (term)
            TERM_X0: slot = SLOT_B0;
            TERM_X1: slot = SLOT_B1;
            TERM_X2: slot = SLOT_B2;
            TERM_Y1: slot = SLOT_A1;
            TERM_Y2: slot = SLOT_A2;
            default: slot = SLOT_B0;
        endcase
        return slot;
    endfunction

endpackage

>>> src/bqc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bqc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/biquad_cascade_filter.sv
// Top level of the cascaded direct-form-I biquad filter with bit-serial multiply and divide.
//
// Cascade of up to MAX_SECTIONS direct-form-I biquads in fixed point (data Q12.12,
// coefficients Q4.20 at the default widths). An input request with tuser = 1 writes one
// coefficient into the coefficient RAM and returns nothing; a request with tuser = 0 filters
// one sample and returns one result with a clipped flag in tuser. All arithmetic goes
// through one shift-and-add multiplier (one multiplier bit per cycle) and one restoring
// divider (one quotient bit per cycle). Each section in use runs five products (RAM
// fetch, load, shift-add, accumulate), an a0 fetch, DVW divide steps with DVW =
// min(DATA_WIDTH + COEF_WIDTH + 1, 62), saturation and history update. One item is in
// work at a time; a finished result waits in the output register while the next request
// is taken. Coefficients must be written before the first sample; histories clear at reset.
module biquad_cascade_filter
    import bqc_pkg::*;
#(
    parameter int MAX_SECTIONS = DEF_MAX_SECTIONS,
    parameter int DATA_WIDTH   = DEF_DATA_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int S_TDATA_W    = ((DATA_WIDTH + 2 + SLOT_W + COEF_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_in, coef_section, coef_slot, coef_value (lowest bit up), zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // action
    input  logic                   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sample_out, zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    // clipped
    output logic                   m_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]  cfg_data
);

    localparam int DW     = DATA_WIDTH;
    localparam int CW     = COEF_WIDTH;
    localparam int PW     = DW + CW;
    localparam int EW     = (PW + 2 > 64) ? PW + 2 : 64;
    localparam int DVW    = (PW + 1 < 62) ? PW + 1 : 62;
    localparam int CNT_W  = $clog2(DVW + 1);
    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int DEPTH  = MAX_SECTIONS * 8;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [EW-1:0] ACC_LIM  = {{(EW-62){1'b0}}, 1'b1, {61{1'b0}}};
    localparam logic [EW-1:0] ACC_NLIM = ~ACC_LIM + 1'b1;
    localparam logic [DVW-1:0] Q_POS = {{(DVW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [DVW-1:0] Q_NEG = {{(DVW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_ACC   = 4'd4;
    localparam logic [3:0] ST_FA0   = 4'd5;
    localparam logic [3:0] ST_DIVLD = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_QSAT  = 4'd8;
    localparam logic [3:0] ST_STORE = 4'd9;

    // Input fields
    logic [DW-1:0]     in_sample;
    logic [1:0]        in_section;
    logic [SLOT_W-1:0] in_slot;
    logic [CW-1:0]     in_coef;

    assign in_sample  = s_tdata[DW-1:0];
    assign in_section = s_tdata[DW+1:DW];
    assign in_slot    = s_tdata[DW+2+SLOT_W-1:DW+2];
    assign in_coef    = s_tdata[DW+2+SLOT_W+CW-1:DW+2+SLOT_W];

    // Control and payload registers
    logic [3:0]            state_reg, state_next;
    logic [TERM_W-1:0]     term_reg, term_next;
    logic [SEC_W-1:0]      sec_reg, sec_next;
    logic [SEC_W-1:0]      last_reg, last_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  mvalid_reg, mvalid_next;
    logic [SECTIONS_W-1:0] siu_reg, siu_next;
    logic [DW-1:0]         omin_reg, omin_next;
    logic [DW-1:0]         omax_reg, omax_next;

    logic [DW-1:0]         x_reg, x_next;
    logic [DW-1:0]         y_reg, y_next;
    logic [EW-1:0]         acc_reg, acc_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [DW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         cmag_reg, cmag_next;
    logic                  psign_reg, psign_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [DVW-1:0]        dv_reg, dv_next;
    logic                  qsign_reg, qsign_next;
    logic [DW-1:0]         mout_reg, mout_next;
    logic                  mclip_reg, mclip_next;

    logic [DW-1:0] x1_reg [MAX_SECTIONS];
    logic [DW-1:0] x2_reg [MAX_SECTIONS];
    logic [DW-1:0] y1_reg [MAX_SECTIONS];
    logic [DW-1:0] y2_reg [MAX_SECTIONS];
    logic          hist_we;

    // Coefficient RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CW-1:0]     ram_rdata;
    logic [SLOT_W-1:0] rd_slot;

    logic in_take;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ram_we    = in_take && s_tuser && (32'(in_section) < MAX_SECTIONS)
                       && (in_slot < NUM_SLOTS);
    assign ram_waddr = ADDR_W'({SEC_W'(in_section), in_slot});
    assign rd_slot   = (state_reg == ST_FA0) ? SLOT_A0 : term_slot(term_reg);
    assign ram_raddr = ADDR_W'({sec_reg, rd_slot});

    bqc_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_coef),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Datapath helpers
    logic [DW-1:0]  operand;
    logic [DW-1:0]  op_mag;
    logic [CW-1:0]  coef_mag;
    logic [CW:0]    mul_sum;
    logic [EW-1:0]  pext;
    logic [EW-1:0]  acc_sum;
    logic           p_over;
    logic           sum_over;
    logic [EW-1:0]  acc_mag;
    logic [CW:0]    rem_shift;
    logic [CW:0]    rem_diff;
    logic           rem_ge;
    logic [DW-1:0]  clamped;
    logic           out_free;

    always_comb begin
        unique case (term_reg)
            TERM_X0: operand = x_reg;
            TERM_X1: operand = x1_reg[sec_reg];
            TERM_X2: operand = x2_reg[sec_reg];
            TERM_Y1: operand = y1_reg[sec_reg];
            TERM_Y2: operand = y2_reg[sec_reg];
            default: operand = x_reg;
        endcase
    end

    assign op_mag   = operand[DW-1] ? (~operand + 1'b1) : operand;
    assign coef_mag = ram_rdata[CW-1] ? (~ram_rdata + 1'b1) : ram_rdata;
    assign mul_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, cmag_reg} : {(CW+1){1'b0}});

    assign pext     = {{(EW-PW){1'b0}}, hi_reg, lo_reg};
    assign acc_sum  = psign_reg ? (acc_reg - pext) : (acc_reg + pext);
    assign p_over   = pext > ACC_LIM;
    assign sum_over = ($signed(acc_sum) > $signed(ACC_LIM))
                      || ($signed(acc_sum) < $signed(ACC_NLIM));
    assign acc_mag  = acc_reg[EW-1] ? (~acc_reg + 1'b1) : acc_reg;

    assign rem_shift = {rem_reg, dv_reg[DVW-1]};
    assign rem_diff  = rem_shift - {1'b0, cmag_reg};
    assign rem_ge    = rem_shift >= {1'b0, cmag_reg};

    always_comb begin
        if ($signed(y_reg) < $signed(omin_reg)) begin
            clamped = omin_reg;
        end else if ($signed(y_reg) > $signed(omax_reg)) begin
            clamped = omax_reg;
        end else begin
            clamped = y_reg;
        end
    end

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        term_next   = term_reg;
        sec_next    = sec_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        siu_next    = siu_reg;
        omin_next   = omin_reg;
        omax_next   = omax_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        cmag_next   = cmag_reg;
        psign_next  = psign_reg;
        rem_next    = rem_reg;
        dv_next     = dv_reg;
        qsign_next  = qsign_reg;
        mout_next   = mout_reg;
        mclip_next  = mclip_reg;
        hist_we     = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SECTIONS: siu_next  = cfg_data[SECTIONS_W-1:0];
                REG_OUT_MIN:  omin_next = cfg_data;
                REG_OUT_MAX:  omax_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take && !s_tuser) begin
                    x_next    = in_sample;
                    sec_next  = '0;
                    term_next = TERM_X0;
                    acc_next  = '0;
                    if (32'(siu_reg) >= MAX_SECTIONS) begin
                        last_next = SEC_W'(MAX_SECTIONS - 1);
                    end else if (siu_reg == '0) begin
                        last_next = '0;
                    end else begin
                        last_next = SEC_W'(siu_reg - 1'b1);
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmag_next  = coef_mag;
                lo_next    = op_mag;
                hi_next    = '0;
                // a1 and a2 enter with negated sign
                psign_next = ((term_reg >= TERM_Y1) ? ~ram_rdata[CW-1] : ram_rdata[CW-1])
                             ^ operand[DW-1];
                cnt_next   = CNT_W'(DW);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                hi_next  = mul_sum[CW:1];
                lo_next  = {mul_sum[0], lo_reg[DW-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (p_over) begin
                    y_next     = psign_reg ? DMIN : DMAX;
                    state_next = ST_STORE;
                end else if (sum_over) begin
                    y_next     = acc_sum[EW-1] ? DMIN : DMAX;
                    state_next = ST_STORE;
                end else begin
                    acc_next = acc_sum;
                    if (term_reg == TERM_Y2) begin
                        state_next = ST_FA0;
                    end else begin
                        term_next  = term_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FA0: begin
                state_next = ST_DIVLD;
            end
            ST_DIVLD: begin
                if (ram_rdata == '0) begin
                    y_next     = acc_reg[EW-1] ? DMIN : DMAX;
                    state_next = ST_STORE;
                end else begin
                    cmag_next  = coef_mag;
                    qsign_next = ram_rdata[CW-1] ^ acc_reg[EW-1];
                    dv_next    = acc_mag[DVW-1:0];
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DVW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one restoring step: quotient bit shifts in behind the dividend
                rem_next = rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
                dv_next  = {dv_reg[DVW-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_QSAT;
                end
            end
            ST_QSAT: begin
                if (qsign_reg) begin
                    y_next = (dv_reg > Q_NEG) ? DMIN : (~dv_reg[DW-1:0] + 1'b1);
                end else begin
                    y_next = (dv_reg > Q_POS) ? DMAX : dv_reg[DW-1:0];
                end
                state_next = ST_STORE;
            end
            ST_STORE: begin
                if (sec_reg != last_reg) begin
                    hist_we    = 1'b1;
                    sec_next   = sec_reg + 1'b1;
                    x_next     = y_reg;
                    term_next  = TERM_X0;
                    acc_next   = '0;
                    state_next = ST_FETCH;
                end else if (out_free) begin
                    // hold here until the output register is free
                    hist_we     = 1'b1;
                    mout_next   = clamped;
                    mclip_next  = (clamped != y_reg);
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            term_reg   <= TERM_X0;
            sec_reg    <= '0;
            last_reg   <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
            siu_reg    <= SECTIONS_W'(1);
            omin_reg   <= DMIN;
            omax_reg   <= DMAX;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            term_reg   <= term_next;
            sec_reg    <= sec_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
            siu_reg    <= siu_next;
            omin_reg   <= omin_next;
            omax_reg   <= omax_next;
            if (hist_we) begin
                x2_reg[sec_reg] <= x1_reg[sec_reg];
                x1_reg[sec_reg] <= x_reg;
                y2_reg[sec_reg] <= y1_reg[sec_reg];
                y1_reg[sec_reg] <= y_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        cmag_reg  <= cmag_next;
        psign_reg <= psign_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        qsign_reg <= qsign_next;
        mout_reg  <= mout_next;
        mclip_reg <= mclip_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = M_TDATA_W'(mout_reg);
    assign m_tuser  = mclip_reg;

endmodule
